### rtl/core/qssc_pkg.sv
`timescale 1ns / 1ps
// Package for the quantized state-space controller: payload structs, codes,
// widths and the control structs passed between sequencer and arithmetic unit.
// No dependencies.
package qssc_pkg;

  // Default sizing of the top level
  localparam int unsigned MAX_STATES_DEF = 8;
  localparam int unsigned COEF_WIDTH_DEF = 32;

  // Fixed datapath widths
  localparam int unsigned ACC_W   = 192;  // exact accumulator
  localparam int unsigned STATE_W = 64;   // controller state element
  localparam int unsigned DIV_W   = 32;   // output divisor
  localparam int unsigned CTRL_W  = 32;   // control output

  // Item actions
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DIVISOR = 1'b0;
  localparam logic CFG_STATES  = 1'b1;

  localparam logic [3:0] STATES_RESET  = 4'd8;
  localparam logic [31:0] DIVISOR_RESET = 32'd1;

  // Coefficient store depth for a given state count
  function automatic int unsigned coef_depth(input int unsigned m);
    return m * (m + 2) + m + 1;
  endfunction

  typedef struct packed {
    logic              action;
    logic [6:0]        coef_index;
    logic signed [31:0] coef_value;
    logic signed [23:0] error_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] control_value;
    logic               saturated;
  } out_item_t;

  // Sequencer commands to the arithmetic unit
  typedef struct packed {
    logic       acc_clr;
    logic       prep;
    logic       mul;
    logic [1:0] step;
    logic       div_init;
    logic       div_step;
  } arith_ctl_t;

  // Sequencer status to the top level
  typedef struct packed {
    logic idle;
    logic take_u;
    logic take_x;
    logic finish;
  } seq_stat_t;

endpackage

### rtl/core/qssc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qssc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 89,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/qssc_arith.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: 32x32 partial-product multiply-accumulate into a
// 192-bit accumulator, bit-serial restoring divider, rounding and saturation.
// Depends on qssc_pkg.
module qssc_arith #(
  parameter int unsigned COEF_WIDTH = qssc_pkg::COEF_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qssc_pkg::arith_ctl_t     ctl_i,
  input  logic [COEF_WIDTH-1:0]    coef_i,
  input  logic signed [63:0]       opb_i,
  input  logic [31:0]              divisor_i,
  output logic [31:0]              u_o,
  output logic                     u_clip_o,
  output logic [63:0]              x_o,
  output logic                     x_clip_o
);

  localparam int unsigned AW = qssc_pkg::ACC_W;

  logic [63:0]    ma_q, mb_q;
  logic           sgn_q;
  logic [63:0]    pp_q;
  logic [1:0]     sh_q;
  logic           pp_vld_q;
  logic [AW-1:0]  acc_q, acc_d;
  logic [31:0]    rem_q, rem_d;
  logic           neg_q;

  // Operand magnitudes and product sign
  logic signed [63:0] a_ext;
  logic [63:0]        ma_d, mb_d;
  assign a_ext = 64'($signed(coef_i));
  assign ma_d  = a_ext[63] ? (~a_ext + 64'd1) : a_ext;
  assign mb_d  = opb_i[63] ? (~opb_i + 64'd1) : opb_i;

  // One 32x32 partial product per step
  logic [31:0] pa, pb;
  logic [63:0] pp_d;
  assign pa   = ctl_i.step[1] ? ma_q[63:32] : ma_q[31:0];
  assign pb   = ctl_i.step[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp_d = pa * pb;

  // Aligned partial product
  logic [AW-1:0] term;
  assign term = {{(AW - 64){1'b0}}, pp_q} << {sh_q, 5'b0};

  // Divider step: one quotient bit into the low end of the accumulator
  logic [31:0] dvs;
  logic [32:0] cur, d33, diff;
  logic        ge;
  assign dvs  = (divisor_i == 32'd0) ? 32'd1 : divisor_i;
  assign cur  = {rem_q, acc_q[AW-1]};
  assign d33  = {1'b0, dvs};
  assign ge   = cur >= d33;
  assign diff = cur - d33;
  assign rem_d = ge ? diff[31:0] : cur[31:0];

  // Accumulator next value
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctl_i.div_init) begin
      acc_d = acc_q[AW-1] ? (~acc_q + AW'(1)) : acc_q;
    end else if (ctl_i.div_step) begin
      acc_d = {acc_q[AW-2:0], ge};
    end else if (pp_vld_q) begin
      acc_d = sgn_q ? (acc_q - term) : (acc_q + term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_vld_q <= 1'b0;
    end else begin
      pp_vld_q <= ctl_i.mul;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.prep) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      sgn_q <= a_ext[63] ^ opb_i[63];
    end
    if (ctl_i.mul) begin
      pp_q <= pp_d;
      sh_q <= {1'b0, ctl_i.step[1]} + {1'b0, ctl_i.step[0]};
    end
    if (ctl_i.div_init) begin
      neg_q <= acc_q[AW-1];
      rem_q <= '0;
    end else if (ctl_i.div_step) begin
      rem_q <= rem_d;
    end
  end

  // Round half away from zero, saturate to 32 bits
  logic        rnd, high;
  logic [32:0] q0;
  logic [31:0] qs;
  assign rnd  = {rem_q, 1'b0} >= {1'b0, dvs};
  assign q0   = {1'b0, acc_q[31:0]} + 33'(rnd);
  assign high = |acc_q[AW-1:32];

  always_comb begin
    if (neg_q) begin
      u_clip_o = high || (q0 > 33'h0_8000_0000);
      qs       = u_clip_o ? 32'h8000_0000 : q0[31:0];
      u_o      = ~qs + 32'd1;
    end else begin
      u_clip_o = high || (q0 > 33'h0_7fff_ffff);
      qs       = u_clip_o ? 32'h7fff_ffff : q0[31:0];
      u_o      = qs;
    end
  end

  // State element saturation to 64 bits
  logic fits;
  assign fits     = (&acc_q[AW-1:63]) || !(|acc_q[AW-1:63]);
  assign x_clip_o = !fits;
  assign x_o      = fits ? acc_q[63:0]
                  : (acc_q[AW-1] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff);

endmodule

### rtl/core/qssc_seq.sv
`timescale 1ns / 1ps
// Sequencer: walks the output row and the state rows term by term, drives
// coefficient reads and the arithmetic unit, and runs the divider count.
// Depends on qssc_pkg.
module qssc_seq #(
  parameter int unsigned MAX_STATES = qssc_pkg::MAX_STATES_DEF,
  localparam int unsigned NW = $clog2(MAX_STATES + 1),
  localparam int unsigned CW = $clog2(MAX_STATES + 2),
  localparam int unsigned AW = $clog2(qssc_pkg::coef_depth(MAX_STATES))
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NW-1:0]        n_i,
  input  logic                 release_i,
  output qssc_pkg::arith_ctl_t ctl_o,
  output qssc_pkg::seq_stat_t  stat_o,
  output logic [CW-1:0]        col_o,
  output logic [NW-1:0]        row_o,
  output logic [NW-1:0]        n_o,
  output logic                 re_o,
  output logic [AW-1:0]        raddr_o
);

  localparam int unsigned DCW = $clog2(qssc_pkg::ACC_W);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_ADDR  = 10'b00_0000_0010,
    S_PREP  = 10'b00_0000_0100,
    S_MUL   = 10'b00_0000_1000,
    S_DRAIN = 10'b00_0001_0000,
    S_DIVI  = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_ROUND = 10'b00_1000_0000,
    S_SAT   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } seq_state_e;

  seq_state_e     state_q, state_d;
  logic [NW-1:0]  n_q, n_d;
  logic [NW-1:0]  r_q, r_d;
  logic [CW-1:0]  c_q, c_d;
  logic [AW-1:0]  base_q, base_d;
  logic [1:0]     step_q, step_d;
  logic [DCW-1:0] cnt_q, cnt_d;
  logic           out_row_q, out_row_d;
  logic           last;

  // Last term of a row: error column for the output row, control column else
  assign last = out_row_q ? (c_q == CW'(n_q)) : (c_q == CW'(n_q) + CW'(1));

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    r_d       = r_q;
    c_d       = c_q;
    base_d    = base_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    out_row_d = out_row_q;
    ctl_o     = '0;
    stat_o    = '0;
    re_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        stat_o.idle = 1'b1;
        if (start_i) begin
          n_d           = n_i;
          c_d           = '0;
          out_row_d     = 1'b1;
          base_d        = AW'(n_i) * (AW'(n_i) + AW'(2));
          ctl_o.acc_clr = 1'b1;
          state_d       = S_ADDR;
        end
      end
      S_ADDR: begin
        re_o    = 1'b1;
        state_d = S_PREP;
      end
      S_PREP: begin
        ctl_o.prep = 1'b1;
        step_d     = '0;
        state_d    = S_MUL;
      end
      S_MUL: begin
        ctl_o.mul  = 1'b1;
        ctl_o.step = step_q;
        step_d     = step_q + 2'd1;
        if (step_q == 2'd3) begin
          if (last) begin
            state_d = S_DRAIN;
          end else begin
            c_d     = c_q + CW'(1);
            state_d = S_ADDR;
          end
        end
      end
      // last partial product lands in the accumulator here
      S_DRAIN: begin
        state_d = out_row_q ? S_DIVI : S_SAT;
      end
      S_DIVI: begin
        ctl_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        cnt_d          = cnt_q + DCW'(1);
        if (cnt_q == DCW'(qssc_pkg::ACC_W - 1)) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        stat_o.take_u = 1'b1;
        ctl_o.acc_clr = 1'b1;
        out_row_d     = 1'b0;
        r_d           = '0;
        base_d        = '0;
        c_d           = '0;
        state_d       = S_ADDR;
      end
      S_SAT: begin
        stat_o.take_x = 1'b1;
        if (r_q == n_q - NW'(1)) begin
          state_d = S_DONE;
        end else begin
          r_d           = r_q + NW'(1);
          base_d        = base_q + AW'(n_q) + AW'(2);
          c_d           = '0;
          ctl_o.acc_clr = 1'b1;
          state_d       = S_ADDR;
        end
      end
      S_DONE: begin
        if (release_i) begin
          stat_o.finish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      n_q       <= '0;
      r_q       <= '0;
      c_q       <= '0;
      base_q    <= '0;
      step_q    <= '0;
      cnt_q     <= '0;
      out_row_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      r_q       <= r_d;
      c_q       <= c_d;
      base_q    <= base_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      out_row_q <= out_row_d;
    end
  end

  assign raddr_o   = base_q + AW'(c_q);
  assign col_o     = c_q;
  assign row_o     = r_q;
  assign n_o       = n_q;

endmodule

### rtl/core/quantized_state_space_controller.sv
`timescale 1ns / 1ps
// Quantized SISO state-space controller: one input channel carrying load and
// sample items, one result channel, a configuration write port.
// Input, output and config channels: valid/stall (input, output), valid/ready (config).
// A load item (action 0) writes one coefficient into the coefficient RAM and
// is taken without raising in_stall_o; it produces no result.
// A sample item (action 1) forms the output-row dot product, divides it by
// output_divisor with round-half-away and 32-bit saturation, then updates all
// N state rows with 64-bit saturation, and yields one result item.
// Each product term runs on the single shared 32x32 multiplier as a read, a
// magnitude prep and four partial products; the division yields one quotient
// bit per cycle. in_stall_o is high from the accepting edge until the result
// is written to the output register, where it is valid from the edge that
// ends the stall. The next item is accepted while the result waits, and a
// later sample only holds at its end until the register frees. Reset clears
// the controller state to zero, sets output_divisor to 1 and
// states_in_use to 8. Coefficients are undefined until loaded. Configuration
// is accepted only while idle and no input item is offered.
module quantized_state_space_controller #(
  parameter int unsigned MAX_STATES = qssc_pkg::MAX_STATES_DEF,
  parameter int unsigned COEF_WIDTH = qssc_pkg::COEF_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qssc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qssc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned CDEPTH = qssc_pkg::coef_depth(MAX_STATES);
  localparam int unsigned AW = $clog2(CDEPTH);
  localparam int unsigned NW = $clog2(MAX_STATES + 1);
  localparam int unsigned CW = $clog2(MAX_STATES + 2);
  localparam int unsigned XW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;

  qssc_pkg::arith_ctl_t ctl;
  qssc_pkg::seq_stat_t  stat;

  logic [31:0]           divisor_q;
  logic [3:0]            states_q;
  logic signed [23:0]    e_q;
  logic [31:0]           u_q;
  logic                  clip_q;
  logic [63:0]           x_q    [MAX_STATES];
  logic [63:0]           newx_q [MAX_STATES];
  logic                  out_vld_q;
  qssc_pkg::out_item_t   out_q;

  logic                  accept, load, start, release_ok, ram_we;
  logic [NW-1:0]         n_sel, n_cur, row;
  logic [CW-1:0]         col;
  logic                  ram_re;
  logic [AW-1:0]         raddr;
  logic [COEF_WIDTH-1:0] coef;
  logic signed [63:0]    opb;
  logic [31:0]           u_w;
  logic                  u_clip;
  logic [63:0]           x_w;
  logic                  x_clip;

  // Handshakes
  assign in_stall_o  = !stat.idle;
  assign cfg_ready_o = stat.idle && !in_valid_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign load        = accept && (in_data_i.action == qssc_pkg::ACT_LOAD);
  assign start       = accept && (in_data_i.action == qssc_pkg::ACT_SAMPLE);
  assign ram_we      = load && (32'(in_data_i.coef_index) < CDEPTH);
  assign release_ok  = !(out_vld_q && out_stall_i);

  // Effective state count, clamped to 1..MAX_STATES
  always_comb begin
    if (states_q == 4'd0) begin
      n_sel = NW'(1);
    end else if (32'(states_q) > MAX_STATES) begin
      n_sel = NW'(MAX_STATES);
    end else begin
      n_sel = NW'(states_q);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= qssc_pkg::DIVISOR_RESET;
      states_q  <= qssc_pkg::STATES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        qssc_pkg::CFG_DIVISOR: divisor_q <= cfg_data_i;
        qssc_pkg::CFG_STATES:  states_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  qssc_ram #(
    .WIDTH (COEF_WIDTH),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_data_i.coef_index)),
    .wdata_i (COEF_WIDTH'(in_data_i.coef_value)),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (coef)
  );

  qssc_seq #(
    .MAX_STATES (MAX_STATES)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .n_i       (n_sel),
    .release_i (release_ok),
    .ctl_o     (ctl),
    .stat_o    (stat),
    .col_o     (col),
    .row_o     (row),
    .n_o       (n_cur),
    .re_o      (ram_re),
    .raddr_o   (raddr)
  );

  // Second operand: state element, error, or control output
  always_comb begin
    if (col < CW'(n_cur)) begin
      opb = x_q[col[XW-1:0]];
    end else if (col == CW'(n_cur)) begin
      opb = 64'(e_q);
    end else begin
      opb = 64'($signed(u_q));
    end
  end

  qssc_arith #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .coef_i    (coef),
    .opb_i     (opb),
    .divisor_i (divisor_q),
    .u_o       (u_w),
    .u_clip_o  (u_clip),
    .x_o       (x_w),
    .x_clip_o  (x_clip)
  );

  // Per-sample payload registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      e_q <= in_data_i.error_sample;
    end
    if (stat.take_u) begin
      u_q <= u_w;
    end
    if (stat.take_x) begin
      newx_q[row[XW-1:0]] <= x_w;
    end
    if (stat.finish) begin
      out_q.control_value <= u_q;
      out_q.saturated     <= clip_q;
    end
  end

  // Clip flag, controller state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q    <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < int'(MAX_STATES); i++) begin
        x_q[i] <= '0;
      end
    end else begin
      if (start) begin
        clip_q <= 1'b0;
      end else if ((stat.take_u && u_clip) || (stat.take_x && x_clip)) begin
        clip_q <= 1'b1;
      end
      if (stat.finish) begin
        for (int i = 0; i < int'(MAX_STATES); i++) begin
          if (i < int'(n_cur)) begin
            x_q[i] <= newx_q[i];
          end
        end
      end
      if (stat.finish) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("sample item accepted but block not busy");

  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> !in_stall_o)
    else $error("load item held the block");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (32'(raddr) < CDEPTH))
    else $error("coefficient read beyond store");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.finish |-> (!out_vld_q || !out_stall_i))
    else $error("result overwrote a pending item");

endmodule
